// ===== src/cmt_pkg.sv =====
// Types, constants and the arctangent table shared by the coincidence trial pipeline.
`timescale 1ns / 1ps
`default_nettype none
package cmt_pkg;

  localparam int POS_W   = 20;
  localparam int PHASE_W = 32;
  localparam int ROOT_W  = 16;
  localparam int NUM_W   = 38;
  localparam int HALF_W  = 19;
  localparam int GAIN_W  = 30;
  localparam int PROD_W  = HALF_W + GAIN_W;
  localparam int X0_W    = 34;
  localparam int XY_W    = 37;
  localparam int Z_W     = 33;
  localparam int SUM_W   = XY_W + 1;

  localparam logic [GAIN_W-1:0] CORDIC_GAIN = 30'd652032874;

  localparam logic [1:0] REG_PLATE_GAP    = 2'd0;
  localparam logic [1:0] REG_PLATE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_PLATE_LENGTH = 2'd2;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_e;

  typedef struct packed {
    logic [POS_W-1:0]   x1;
    logic [POS_W-1:0]   y1;
    logic [PHASE_W-1:0] phase;
    logic               restart;
  } trial_t;

  typedef struct packed {
    trial_t            trial;
    logic [ROOT_W-1:0] c;
  } trial_cos_t;

  typedef struct packed {
    trial_t trial;
    logic   cnz;
  } trial_nz_t;

  typedef struct packed {
    logic [POS_W-1:0] x1;
    logic [POS_W-1:0] y1;
    quad_e            quad;
    logic             restart;
    logic             cnz;
  } tail_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] hits;
    logic [31:0] trials;
  } res_t;

  function automatic logic [31:0] cmt_atan(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      5'd24:   a = 32'd41;
      5'd25:   a = 32'd20;
      5'd26:   a = 32'd10;
      5'd27:   a = 32'd5;
      5'd28:   a = 32'd3;
      5'd29:   a = 32'd1;
      5'd30:   a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== src/cmt_isqrt.sv =====
// Pipelined floor square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module cmt_isqrt #(
  parameter int IN_W   = 32,
  parameter int SIDE_W = 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic [IN_W-1:0]     rad_i,
  input  wire logic [SIDE_W-1:0]   side_i,
  output logic                     valid_o,
  output logic [IN_W/2-1:0]        root_o,
  output logic [SIDE_W-1:0]        side_o
);

  localparam int OUT_W = IN_W / 2;

  logic              vld_q  [OUT_W];
  logic [IN_W-1:0]   rem_q  [OUT_W];
  logic [OUT_W-1:0]  root_q [OUT_W];
  logic [SIDE_W-1:0] side_q [OUT_W];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    localparam int B = OUT_W - 1 - k;
    logic              v_in;
    logic [IN_W-1:0]   rem_in;
    logic [OUT_W-1:0]  root_in;
    logic [SIDE_W-1:0] side_in;
    logic [IN_W:0]     trial;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_rest
      assign v_in    = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = ((IN_W+1)'(root_in) << (B + 1)) + ((IN_W+1)'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        if ({1'b0, rem_in} >= trial) begin
          rem_q[k]  <= rem_in - trial[IN_W-1:0];
          root_q[k] <= root_in | (OUT_W'(1) << B);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign valid_o = vld_q[OUT_W-1];
  assign root_o  = root_q[OUT_W-1];
  assign side_o  = side_q[OUT_W-1];

endmodule
`default_nettype wire

// ===== src/cmt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module cmt_div #(
  parameter int NUM_W  = 38,
  parameter int DEN_W  = 16,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [NUM_W-1:0]       quot_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic              vld_q  [NUM_W];
  logic [DEN_W-1:0]  rem_q  [NUM_W];
  logic [NUM_W-1:0]  nq_q   [NUM_W];
  logic [DEN_W-1:0]  den_q  [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              v_in;
    logic [DEN_W-1:0]  rem_in;
    logic [NUM_W-1:0]  nq_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    sh;
    logic              take;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign nq_in   = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_rest
      assign v_in    = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign sh   = {rem_in, nq_in[NUM_W-1]};
    assign take = sh >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        den_q[k]  <= den_in;
        nq_q[k]   <= {nq_in[NUM_W-2:0], take};
        if (take) begin
          rem_q[k] <= DEN_W'(sh - {1'b0, den_in});
        end else begin
          rem_q[k] <= sh[DEN_W-1:0];
        end
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quot_o  = nq_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];

endmodule
`default_nettype wire

// ===== src/cmt_cordic.sv =====
// Pipelined CORDIC rotator, one micro-rotation per stage, angles in turns.
`timescale 1ns / 1ps
`default_nettype none
module cmt_cordic #(
  parameter int STAGES = 16,
  parameter int XY_W   = 37,
  parameter int Z_W    = 33,
  parameter int SIDE_W = 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic signed [XY_W-1:0] x_i,
  input  wire logic signed [Z_W-1:0]  z_i,
  input  wire logic [SIDE_W-1:0]      side_i,
  output logic                        valid_o,
  output logic signed [XY_W-1:0]      x_o,
  output logic signed [XY_W-1:0]      y_o,
  output logic [SIDE_W-1:0]           side_o
);

  import cmt_pkg::*;

  logic                   vld_q  [STAGES];
  logic signed [XY_W-1:0] x_q    [STAGES];
  logic signed [XY_W-1:0] y_q    [STAGES];
  logic signed [Z_W-1:0]  z_q    [STAGES];
  logic [SIDE_W-1:0]      side_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic                   v_in;
    logic signed [XY_W-1:0] x_in;
    logic signed [XY_W-1:0] y_in;
    logic signed [Z_W-1:0]  z_in;
    logic [SIDE_W-1:0]      side_in;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  ang;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign x_in    = x_i;
      assign y_in    = '0;
      assign z_in    = z_i;
      assign side_in = side_i;
    end else begin : g_rest
      assign v_in    = vld_q[i-1];
      assign x_in    = x_q[i-1];
      assign y_in    = y_q[i-1];
      assign z_in    = z_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign dx  = y_in >>> i;
    assign dy  = x_in >>> i;
    assign ang = $signed(Z_W'(cmt_atan(5'(i))));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i] <= side_in;
        if (!z_in[Z_W-1]) begin
          x_q[i] <= x_in - dx;
          y_q[i] <= y_in + dy;
          z_q[i] <= z_in - ang;
        end else begin
          x_q[i] <= x_in + dx;
          y_q[i] <= y_in - dy;
          z_q[i] <= z_in + ang;
        end
      end
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign x_o     = x_q[STAGES-1];
  assign y_o     = y_q[STAGES-1];
  assign side_o  = side_q[STAGES-1];

endmodule
`default_nettype wire

// ===== src/muon_coincidence_trial.sv =====
// Throughput: one item per cycle while in_ready_o is high; the divider (38 stages), three root units
// and the CORDIC chain are fully pipelined and a two-entry output buffer absorbs stalls.
// Reset: asynchronous, active low; clears valid bits and both running counters and
// loads plate_gap 160, plate_width 160, plate_length 496. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module muon_coincidence_trial #(
  parameter int SAMPLE_BITS   = 16,
  parameter int COUNT_BITS    = 32,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] sample_x_i,
  input  wire logic [15:0] sample_y_i,
  input  wire logic [15:0] sample_cos_i,
  input  wire logic [15:0] sample_phi_i,
  input  wire logic        restart_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             hit_o,
  output logic [31:0]      hits_so_far_o,
  output logic [31:0]      trials_so_far_o
);

  import cmt_pkg::*;

  localparam logic [32:0] SMASK_W = (33'(1) << SAMPLE_BITS) - 33'(1);
  localparam logic [31:0] SMASK   = SMASK_W[31:0];
  localparam int          UP      = 32 - SAMPLE_BITS;

  logic [13:0] gap_q;
  logic [11:0] width_q;
  logic [11:0] length_q;

  logic en;

  logic [31:0] sx, sy, sc, sp;
  logic [43:0] prod_x, prod_y;
  trial_t      fr_trial_d;

  logic        fr_v_q;
  trial_t      fr_trial_q;
  logic [31:0] fr_rad_q;

  logic              a_v;
  logic [ROOT_W-1:0] a_root;
  trial_t            a_side;

  logic              b_v;
  logic [ROOT_W-1:0] b_c;
  trial_t            b_side;

  logic        sq_v_q;
  logic [31:0] sq_cc_q;
  trial_cos_t  sq_tc_q;

  logic              s_v;
  logic [ROOT_W-1:0] s_s;
  trial_cos_t        s_side;

  logic              nm_v_q;
  logic [NUM_W-1:0]  nm_num_q;
  logic [ROOT_W-1:0] nm_den_q;
  trial_nz_t         nm_tn_q;

  logic             d_v;
  logic [NUM_W-1:0] d_q;
  trial_nz_t        d_side;

  logic              ml_v_q;
  logic [PROD_W-1:0] ml_lo_q;
  logic [PROD_W-1:0] ml_hi_q;
  trial_nz_t         ml_tn_q;

  logic [67:0] prod_full;
  tail_t       cb_tail_d;

  logic            cb_v_q;
  logic [X0_W-1:0] cb_x0_q;
  logic [29:0]     cb_z_q;
  tail_t           cb_tail_q;

  logic                   co_v;
  logic signed [XY_W-1:0] co_x, co_y;
  tail_t                  co_tail;

  logic signed [XY_W-1:0]  px, py;
  logic signed [SUM_W-1:0] x2, y2, wlim, llim;
  logic                    hit_d;

  logic l_v_q;
  logic l_hit_q;
  logic l_restart_q;

  logic [COUNT_BITS-1:0] hit_total_q, trial_total_q;
  logic [COUNT_BITS-1:0] hit_total_d, trial_total_d;
  logic [COUNT_BITS-1:0] hit_base, trial_base;
  logic                  push;
  res_t                  res_d;

  logic out_v_q, skid_v_q;
  res_t out_q, skid_q;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : COUNT_BITS'(v + 1'b1);
  endfunction

  function automatic logic [31:0] clamp32(input logic [COUNT_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q    <= 14'd160;
      width_q  <= 12'd160;
      length_q <= 12'd496;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_PLATE_GAP:    gap_q    <= pwdata[13:0];
        REG_PLATE_WIDTH:  width_q  <= pwdata[11:0];
        REG_PLATE_LENGTH: length_q <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PLATE_GAP:    prdata = 32'(gap_q);
      REG_PLATE_WIDTH:  prdata = 32'(width_q);
      REG_PLATE_LENGTH: prdata = 32'(length_q);
      default:          prdata = '0;
    endcase
  end

  // front stage: entry point, phase, cosine radicand
  assign en         = !skid_v_q;
  assign in_ready_o = en;

  assign sx = 32'(sample_x_i) & SMASK;
  assign sy = 32'(sample_y_i) & SMASK;
  assign sc = 32'(sample_cos_i) & SMASK;
  assign sp = 32'(sample_phi_i) & SMASK;

  assign prod_x = 44'(width_q) * 44'(sx);
  assign prod_y = 44'(length_q) * 44'(sy);

  always_comb begin
    fr_trial_d.x1      = POS_W'({prod_x, 8'b0} >> SAMPLE_BITS);
    fr_trial_d.y1      = POS_W'({prod_y, 8'b0} >> SAMPLE_BITS);
    fr_trial_d.phase   = sp << UP;
    fr_trial_d.restart = restart_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_v_q <= 1'b0;
    end else if (en) begin
      fr_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fr_trial_q <= fr_trial_d;
      fr_rad_q   <= sc << UP;
    end
  end

  // cosine as fourth root
  cmt_isqrt #(.IN_W(32), .SIDE_W($bits(trial_t))) u_root_a (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(fr_v_q), .rad_i(fr_rad_q), .side_i(fr_trial_q),
    .valid_o(a_v), .root_o(a_root), .side_o(a_side)
  );

  cmt_isqrt #(.IN_W(32), .SIDE_W($bits(trial_t))) u_root_b (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(a_v), .rad_i({a_root, 16'b0}), .side_i(a_side),
    .valid_o(b_v), .root_o(b_c), .side_o(b_side)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= 1'b0;
    end else if (en) begin
      sq_v_q <= b_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_cc_q       <= 32'(b_c) * 32'(b_c);
      sq_tc_q.trial <= b_side;
      sq_tc_q.c     <= b_c;
    end
  end

  // sine from one minus cosine squared
  cmt_isqrt #(.IN_W(32), .SIDE_W($bits(trial_cos_t))) u_root_s (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(sq_v_q), .rad_i(32'd0 - sq_cc_q), .side_i(sq_tc_q),
    .valid_o(s_v), .root_o(s_s), .side_o(s_side)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_v_q <= 1'b0;
    end else if (en) begin
      nm_v_q <= s_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nm_num_q      <= {30'(gap_q) * 30'(s_s), 8'b0};
      nm_den_q      <= s_side.c;
      nm_tn_q.trial <= s_side.trial;
      nm_tn_q.cnz   <= |s_side.c;
    end
  end

  // projected radius
  cmt_div #(.NUM_W(NUM_W), .DEN_W(ROOT_W), .SIDE_W($bits(trial_nz_t))) u_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(nm_v_q), .num_i(nm_num_q), .den_i(nm_den_q), .side_i(nm_tn_q),
    .valid_o(d_v), .quot_o(d_q), .side_o(d_side)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ml_v_q <= 1'b0;
    end else if (en) begin
      ml_v_q <= d_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ml_lo_q <= PROD_W'(d_q[HALF_W-1:0]) * PROD_W'(CORDIC_GAIN);
      ml_hi_q <= PROD_W'(d_q[NUM_W-1:HALF_W]) * PROD_W'(CORDIC_GAIN);
      ml_tn_q <= d_side;
    end
  end

  assign prod_full = {ml_hi_q, 19'b0} + 68'(ml_lo_q);

  always_comb begin
    cb_tail_d.x1      = ml_tn_q.trial.x1;
    cb_tail_d.y1      = ml_tn_q.trial.y1;
    cb_tail_d.quad    = quad_e'(ml_tn_q.trial.phase[31:30]);
    cb_tail_d.restart = ml_tn_q.trial.restart;
    cb_tail_d.cnz     = ml_tn_q.cnz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_v_q <= 1'b0;
    end else if (en) begin
      cb_v_q <= ml_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cb_x0_q   <= prod_full[63:30];
      cb_z_q    <= ml_tn_q.trial.phase[29:0];
      cb_tail_q <= cb_tail_d;
    end
  end

  // azimuth rotation
  cmt_cordic #(
    .STAGES(CORDIC_STAGES), .XY_W(XY_W), .Z_W(Z_W), .SIDE_W($bits(tail_t))
  ) u_cordic (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(cb_v_q),
    .x_i($signed(XY_W'(cb_x0_q))), .z_i($signed(Z_W'(cb_z_q))), .side_i(cb_tail_q),
    .valid_o(co_v), .x_o(co_x), .y_o(co_y), .side_o(co_tail)
  );

  // quadrant fold and plate test
  always_comb begin
    case (co_tail.quad)
      QUAD_I:   begin px = co_x;  py = co_y;  end
      QUAD_II:  begin px = -co_y; py = co_x;  end
      QUAD_III: begin px = -co_x; py = -co_y; end
      default:  begin px = co_y;  py = -co_x; end
    endcase
  end

  assign x2   = $signed(SUM_W'(co_tail.x1)) + SUM_W'(px);
  assign y2   = $signed(SUM_W'(co_tail.y1)) + SUM_W'(py);
  assign wlim = $signed(SUM_W'({width_q, 8'b0}));
  assign llim = $signed(SUM_W'({length_q, 8'b0}));

  assign hit_d = co_tail.cnz && !x2[SUM_W-1] && (x2 < wlim) && !y2[SUM_W-1] && (y2 < llim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_v_q <= 1'b0;
    end else if (en) begin
      l_v_q <= co_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_hit_q     <= hit_d;
      l_restart_q <= co_tail.restart;
    end
  end

  // running totals
  assign push       = l_v_q && en;
  assign hit_base   = l_restart_q ? '0 : hit_total_q;
  assign trial_base = l_restart_q ? '0 : trial_total_q;

  always_comb begin
    trial_total_d = sat_inc(trial_base);
    hit_total_d   = l_hit_q ? sat_inc(hit_base) : hit_base;
    res_d.hit     = l_hit_q;
    res_d.hits    = clamp32(hit_total_d);
    res_d.trials  = clamp32(trial_total_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_total_q   <= '0;
      trial_total_q <= '0;
    end else if (push) begin
      hit_total_q   <= hit_total_d;
      trial_total_q <= trial_total_d;
    end
  end

  // output register and skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= push;
      end
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= res_d;
      end
    end else if (push) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o     = out_v_q;
  assign hit_o           = out_q.hit;
  assign hits_so_far_o   = out_q.hits;
  assign trials_so_far_o = out_q.trials;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held without output item");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_v_q && !out_ready_i) |=> skid_v_q)
    else $error("item lost on output stall");

  a_trial_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !l_restart_q && !(&trial_total_q)) |=>
      (trial_total_q == COUNT_BITS'($past(trial_total_q) + 1'b1)))
    else $error("trial count did not advance");

  a_hits_le_trials: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_total_q <= trial_total_q)
    else $error("hit count exceeds trial count");
`endif

endmodule
`default_nettype wire
